// ===== sv/fodc_pkg.sv =====
`timescale 1ns / 1ps

package fodc_pkg;

  // Field and datapath widths
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned MEAS_W       = 18;
  localparam int unsigned ERR_W        = 19;
  localparam int unsigned DRIVE_W      = 32;
  localparam int unsigned COEF_W       = 24;
  localparam int unsigned SCALE_W      = 16;
  localparam int unsigned DUTY_W       = 13;
  localparam int unsigned PROD_W       = COEF_W + DRIVE_W;
  localparam int unsigned ACC_W        = PROD_W + 2;
  localparam int unsigned OUT_DATA_W   = 32;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 24;

  // Loop constants
  localparam int unsigned DUTY_MAX       = 6800;
  localparam int unsigned COEF_FRAC_BITS = 16;
  localparam int unsigned DUTY_FRAC_BITS = 8;

  // Speed measurement: 1000 / period, ten quotient bits
  localparam int unsigned DIV_W       = 10;
  localparam int unsigned DIV_CNT_W   = 4;
  localparam int unsigned SPEED_NUM   = 1000;
  localparam int unsigned SPEED_SAT   = 256000;

  // Temperature measurement: code * 330 >> 4
  localparam int unsigned TEMP_GAIN   = 330;
  localparam int unsigned TEMP_SHIFT  = 4;
  localparam int unsigned TEMP_PROD_W = SAMPLE_W + 9;
  localparam int unsigned MEAS_MAX    = 262143;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_NOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_PRV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FB  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 3'd6;

  // Microprogram
  localparam int unsigned PROG_LEN = 14;
  localparam int unsigned PC_W     = 4;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_TEMP,
    MUL_NOW,
    MUL_PREV,
    MUL_FB,
    MUL_DUTY
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_DIV,
    ACT_MEAS_SPD,
    ACT_MEAS_TMP,
    ACT_ERR,
    ACT_DRIVE,
    ACT_EMIT
  } act_e;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_IN,
    BR_MODE,
    BR_DIV,
    BR_JUMP,
    BR_OUT
  } br_e;

  typedef struct packed {
    mul_sel_e        mul;
    acc_op_e         acc;
    act_e            act;
    br_e             br;
    logic [PC_W-1:0] tgt;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic mode;
    logic div_last;
    logic out_free;
  } seq_status_t;

endpackage

// ===== sv/fodc_seq.sv =====
`timescale 1ns / 1ps

module fodc_seq import fodc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  seq_status_t status_i,
  output ctrl_word_t  ctrl_o
);

  // Microcode store: one control word per step
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{mul: MUL_NONE, acc: ACC_HOLD, act: ACT_NONE, br: BR_NEXT, tgt: '0};
    unique case (pc)
      4'd0:  begin w.act = ACT_LOAD;     w.br = BR_IN;                  end
      4'd1:  begin                       w.br = BR_MODE; w.tgt = 4'd4;  end
      4'd2:  begin w.act = ACT_DIV;      w.br = BR_DIV;                 end
      4'd3:  begin w.act = ACT_MEAS_SPD; w.br = BR_JUMP; w.tgt = 4'd6;  end
      4'd4:  begin w.mul = MUL_TEMP;                                    end
      4'd5:  begin w.act = ACT_MEAS_TMP;                                end
      4'd6:  begin w.act = ACT_ERR;                                     end
      4'd7:  begin w.mul = MUL_NOW;                                     end
      4'd8:  begin w.mul = MUL_PREV;     w.acc = ACC_LOAD;              end
      4'd9:  begin w.mul = MUL_FB;       w.acc = ACC_ADD;               end
      4'd10: begin                       w.acc = ACC_ADD;               end
      4'd11: begin w.act = ACT_DRIVE;                                   end
      4'd12: begin w.mul = MUL_DUTY;                                    end
      4'd13: begin w.act = ACT_EMIT;     w.br = BR_OUT;  w.tgt = 4'd0;  end
      default: begin                     w.br = BR_JUMP; w.tgt = 4'd0;  end
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_word_t      cw;

  assign cw     = ucode(pc_q);
  assign ctrl_o = cw;

  // Pick the next step
  always_comb begin
    unique case (cw.br)
      BR_NEXT: pc_d = pc_q + 1'b1;
      BR_IN:   pc_d = status_i.in_valid ? pc_q + 1'b1 : pc_q;
      BR_MODE: pc_d = status_i.mode ? cw.tgt : pc_q + 1'b1;
      BR_DIV:  pc_d = status_i.div_last ? pc_q + 1'b1 : pc_q;
      BR_JUMP: pc_d = cw.tgt;
      BR_OUT:  pc_d = status_i.out_free ? cw.tgt : pc_q;
      default: pc_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q < PC_W'(PROG_LEN))
    else $error("step counter left the program");

  a_wait_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.br == BR_IN && !status_i.in_valid) |=> pc_q == $past(pc_q))
    else $error("sequencer left the wait step without a word");

  a_emit_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.br == BR_OUT && status_i.out_free) |=> pc_q == '0)
    else $error("sequencer did not return after emitting");

endmodule

// ===== sv/first_order_duty_compensator.sv =====
`timescale 1ns / 1ps
// In speed mode each sample passes the bit-serial 1000/period divider (ten quotient bits),
//   then the loop steps; temperature mode skips the divider and scales on the multiplier.
// A new sample is taken only at the wait step, once the previous result has been emitted;
//   the microprogram steps one shared 24x32 multiplier; a stalled result holds the last step.
// Reset (rst_ni low, asynchronous) loads the register defaults, clears the previous error and
//   drive, empties the output register and restarts the program at its wait step.

module first_order_duty_compensator import fodc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Sample in
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata_i,   // [15:0] sample
  // Result out
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // [12:0] duty, [30:13] measured, [31] clipped
  // Register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_word_t  ctrl;
  seq_status_t status;

  // Configuration registers
  logic                     mode_q;
  logic [MEAS_W-1:0]        target_q;
  logic signed [COEF_W-1:0] coef_now_q, coef_prev_q, coef_fb_q;
  logic [SCALE_W-1:0]       scale_q, offset_q;

  // Loop state and datapath
  logic [SAMPLE_W-1:0]       sample_q;
  logic [DIV_W-1:0]          rem_q, quo_q;
  logic [DIV_CNT_W-1:0]      cnt_q;
  logic [MEAS_W-1:0]         meas_q;
  logic                      clip_q;
  logic signed [ERR_W-1:0]   err_q, last_err_q;
  logic signed [DRIVE_W-1:0] drive_q, last_drive_q, drive_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d, acc_sh;
  logic                      out_valid_q;
  logic [OUT_DATA_W-1:0]     out_data_q;

  logic in_fire, out_free, out_load;

  fodc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign s_axis_tready_o = (ctrl.act == ACT_LOAD);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign out_load        = (ctrl.act == ACT_EMIT) && out_free;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign status = '{in_valid: s_axis_tvalid_i, mode: mode_q,
                    div_last: (cnt_q == DIV_CNT_W'(DIV_W - 1)), out_free: out_free};

  // Take register writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      target_q    <= MEAS_W'(10240);
      coef_now_q  <= COEF_W'(408748);
      coef_prev_q <= COEF_W'(-407634);
      coef_fb_q   <= COEF_W'(65523);
      scale_q     <= SCALE_W'(136);
      offset_q    <= SCALE_W'(1496);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE:     mode_q      <= cfg_data_i[0];
        REG_TARGET:   target_q    <= cfg_data_i[MEAS_W-1:0];
        REG_COEF_NOW: coef_now_q  <= cfg_data_i;
        REG_COEF_PRV: coef_prev_q <= cfg_data_i;
        REG_COEF_FB:  coef_fb_q   <= cfg_data_i;
        REG_SCALE:    scale_q     <= cfg_data_i[SCALE_W-1:0];
        REG_OFFSET:   offset_q    <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operands
  logic signed [COEF_W-1:0]  mul_a;
  logic signed [DRIVE_W-1:0] mul_b;

  always_comb begin
    unique case (ctrl.mul)
      MUL_TEMP: begin
        mul_a = COEF_W'(TEMP_GAIN);
        mul_b = DRIVE_W'(sample_q);
      end
      MUL_NOW: begin
        mul_a = coef_now_q;
        mul_b = DRIVE_W'(err_q);
      end
      MUL_PREV: begin
        mul_a = coef_prev_q;
        mul_b = DRIVE_W'(last_err_q);
      end
      MUL_FB: begin
        mul_a = coef_fb_q;
        mul_b = last_drive_q;
      end
      MUL_DUTY: begin
        mul_a = COEF_W'(scale_q);
        mul_b = drive_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Accumulate products
  always_comb begin
    unique case (ctrl.acc)
      ACC_LOAD: acc_d = ACC_W'(prod_q);
      ACC_ADD:  acc_d = acc_q + ACC_W'(prod_q);
      default:  acc_d = acc_q;
    endcase
  end

  // Drop fraction bits and saturate the drive to 32 bits
  logic [ACC_W-DRIVE_W:0] acc_hi;
  assign acc_sh = acc_q >>> COEF_FRAC_BITS;
  assign acc_hi = acc_sh[ACC_W-1:DRIVE_W-1];
  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      drive_d = acc_sh[DRIVE_W-1:0];
    end else if (acc_hi[ACC_W-DRIVE_W]) begin
      drive_d = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_d = {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  end

  // Restoring divider step for 1000 / period
  logic [DIV_W:0]      rem_sh;
  logic [SAMPLE_W-1:0] rem_diff;
  logic                rem_ge;
  assign rem_sh   = {rem_q, quo_q[DIV_W-1]};
  assign rem_ge   = SAMPLE_W'(rem_sh) >= sample_q;
  assign rem_diff = SAMPLE_W'(rem_sh) - sample_q;

  // Temperature scaling
  logic [TEMP_PROD_W-TEMP_SHIFT-1:0] temp_full;
  assign temp_full = prod_q[TEMP_PROD_W-1:TEMP_SHIFT];

  // Duty mapping
  localparam int unsigned DSUM_W = PROD_W - DUTY_FRAC_BITS + 1;
  logic [DSUM_W-1:0] dsum;
  logic              duty_big;
  logic [DUTY_W-1:0] duty;
  logic              duty_clip;
  assign dsum     = {1'b0, prod_q[PROD_W-1:DUTY_FRAC_BITS]} + DSUM_W'(offset_q);
  assign duty_big = dsum > DSUM_W'(DUTY_MAX);
  always_comb begin
    if (drive_q[DRIVE_W-1]) begin
      duty      = '0;
      duty_clip = 1'b1;
    end else if (duty_big) begin
      duty      = DUTY_W'(DUTY_MAX);
      duty_clip = 1'b1;
    end else begin
      duty      = dsum[DUTY_W-1:0];
      duty_clip = 1'b0;
    end
  end

  // Datapath registers driven by the control word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= s_axis_tdata_i;
      rem_q    <= '0;
      quo_q    <= DIV_W'(SPEED_NUM);
      cnt_q    <= '0;
      clip_q   <= 1'b0;
    end
    if (ctrl.act == ACT_DIV) begin
      rem_q <= rem_ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], rem_ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (ctrl.act == ACT_MEAS_SPD) begin
      if (sample_q == '0) begin
        meas_q <= MEAS_W'(SPEED_SAT);
        clip_q <= 1'b1;
      end else begin
        meas_q <= {quo_q, {(MEAS_W-DIV_W){1'b0}}};
      end
    end
    if (ctrl.act == ACT_MEAS_TMP) begin
      if (temp_full > (TEMP_PROD_W-TEMP_SHIFT)'(MEAS_MAX)) begin
        meas_q <= MEAS_W'(MEAS_MAX);
        clip_q <= 1'b1;
      end else begin
        meas_q <= temp_full[MEAS_W-1:0];
      end
    end
    if (ctrl.act == ACT_ERR) begin
      err_q <= $signed({1'b0, target_q}) - $signed({1'b0, meas_q});
    end
    if (ctrl.act == ACT_DRIVE) begin
      drive_q <= drive_d;
    end
    if (ctrl.mul != MUL_NONE) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  // Keep the previous error and drive for the next sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q   <= '0;
      last_drive_q <= '0;
    end else if (ctrl.act == ACT_DRIVE) begin
      last_err_q   <= err_q;
      last_drive_q <= drive_d;
    end
  end

  // Output register: load the result word, hold it until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {clip_q | duty_clip, meas_q, duty};
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("sample taken again right after an accept");

  a_load_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("result word overwrote a pending word");

  a_negative_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && drive_q[DRIVE_W-1]) |=>
      (m_axis_tdata_o[DUTY_W-1:0] == '0 && m_axis_tdata_o[OUT_DATA_W-1]))
    else $error("negative drive did not force a clipped zero duty");

endmodule
